[rtl/bqc_pkg.sv]
// Shared types, constants and the micro-program of the biquad coefficient converter.
`default_nettype none

package bqc_pkg;

	// Number of smoothed coefficients that reach the output
	localparam int COEF_COUNT = 8;
	localparam int IDX_W      = $clog2(COEF_COUNT);

	// Q8.24 limits and constants
	localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	localparam logic [15:0] WEIGHT_RESET = 16'd13107;

	// Scratch RAM
	localparam int RAM_DEPTH = 32;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Scratch RAM map: raw inputs, normalised inputs, new coefficients, temporaries
	localparam logic [RAM_AW-1:0] R_A0I = 5'd0;
	localparam logic [RAM_AW-1:0] R_A1  = 5'd1;
	localparam logic [RAM_AW-1:0] R_A2  = 5'd2;
	localparam logic [RAM_AW-1:0] R_B0  = 5'd3;
	localparam logic [RAM_AW-1:0] R_B1  = 5'd4;
	localparam logic [RAM_AW-1:0] R_B2  = 5'd5;
	localparam logic [RAM_AW-1:0] R_G   = 5'd6;
	localparam logic [RAM_AW-1:0] R_NA1 = 5'd7;
	localparam logic [RAM_AW-1:0] R_NA2 = 5'd8;
	localparam logic [RAM_AW-1:0] R_NB0 = 5'd9;
	localparam logic [RAM_AW-1:0] R_NB1 = 5'd10;
	localparam logic [RAM_AW-1:0] R_NB2 = 5'd11;
	localparam logic [RAM_AW-1:0] R_N0  = 5'd12;
	localparam logic [RAM_AW-1:0] R_N1  = 5'd13;
	localparam logic [RAM_AW-1:0] R_N2  = 5'd14;
	localparam logic [RAM_AW-1:0] R_N3  = 5'd15;
	localparam logic [RAM_AW-1:0] R_N4  = 5'd16;
	localparam logic [RAM_AW-1:0] R_N5  = 5'd17;
	localparam logic [RAM_AW-1:0] R_N6  = 5'd18;
	localparam logic [RAM_AW-1:0] R_N7  = 5'd19;
	localparam logic [RAM_AW-1:0] R_T0  = 5'd20;
	localparam logic [RAM_AW-1:0] R_T1  = 5'd21;
	localparam logic [RAM_AW-1:0] R_T2  = 5'd22;

	// Operations of the shared serial unit
	typedef enum logic [3:0] {
		OP_END,
		OP_MUL,
		OP_AI,
		OP_ADD,
		OP_SUB,
		OP_MOV,
		OP_ONE,
		OP_ZERO,
		OP_AR,
		OP_DIV,
		OP_SQRT,
		OP_SMOOTH
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [RAM_AW-1:0] ra;
		logic [RAM_AW-1:0] rb;
		logic [RAM_AW-1:0] rd;
	} instr_t;

	localparam int PC_W = 5;

	// Request and status between sequencer and arithmetic unit
	typedef struct packed {
		logic start;
		op_t  op;
		logic first;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

	function automatic instr_t mk(input op_t op, input logic [RAM_AW-1:0] ra,
			input logic [RAM_AW-1:0] rb, input logic [RAM_AW-1:0] rd);
		instr_t i;
		i.op = op;
		i.ra = ra;
		i.rb = rb;
		i.rd = rd;
		return i;
	endfunction

	// Micro-program: normalisation, then coupled or lattice conversion
	function automatic instr_t prog(input logic lat, input logic [PC_W-1:0] pc);
		instr_t i;
		i = mk(OP_END, R_A0I, R_A0I, R_A0I);
		if (pc < 5'd6) begin
			case (pc)
				5'd0:    i = mk(OP_MUL, R_A1, R_A0I, R_NA1);
				5'd1:    i = mk(OP_MUL, R_A2, R_A0I, R_NA2);
				5'd2:    i = mk(OP_MUL, R_B0, R_A0I, R_NB0);
				5'd3:    i = mk(OP_MUL, R_B1, R_A0I, R_NB1);
				5'd4:    i = mk(OP_MUL, R_B2, R_A0I, R_NB2);
				default: i = mk(OP_MOV, R_G, R_A0I, R_N7);
			endcase
		end else if (!lat) begin
			case (pc)
				5'd6:    i = mk(OP_AR, R_NA1, R_A0I, R_N0);
				5'd7:    i = mk(OP_AI, R_NA1, R_NA2, R_N1);
				5'd8:    i = mk(OP_ONE, R_A0I, R_A0I, R_N2);
				5'd9:    i = mk(OP_ZERO, R_A0I, R_A0I, R_N3);
				5'd10:   i = mk(OP_MUL, R_NA1, R_NB0, R_T0);
				5'd11:   i = mk(OP_SUB, R_NB1, R_T0, R_N4);
				5'd12:   i = mk(OP_MUL, R_NA2, R_NB0, R_T0);
				5'd13:   i = mk(OP_SUB, R_NB2, R_T0, R_T1);
				5'd14:   i = mk(OP_MUL, R_N4, R_N0, R_T0);
				5'd15:   i = mk(OP_ADD, R_T0, R_T1, R_T0);
				5'd16:   i = mk(OP_DIV, R_T0, R_N1, R_N5);
				5'd17:   i = mk(OP_MOV, R_NB0, R_A0I, R_N6);
				default: i = mk(OP_END, R_A0I, R_A0I, R_A0I);
			endcase
		end else begin
			case (pc)
				5'd6:    i = mk(OP_ONE, R_A0I, R_A0I, R_T2);
				5'd7:    i = mk(OP_ADD, R_T2, R_NA2, R_T0);
				5'd8:    i = mk(OP_DIV, R_NA1, R_T0, R_N0);
				5'd9:    i = mk(OP_MOV, R_NA2, R_A0I, R_N1);
				5'd10:   i = mk(OP_MUL, R_N0, R_N0, R_T0);
				5'd11:   i = mk(OP_SUB, R_T2, R_T0, R_T0);
				5'd12:   i = mk(OP_SQRT, R_T0, R_A0I, R_N2);
				5'd13:   i = mk(OP_MUL, R_N1, R_N1, R_T0);
				5'd14:   i = mk(OP_SUB, R_T2, R_T0, R_T0);
				5'd15:   i = mk(OP_SQRT, R_T0, R_A0I, R_N3);
				5'd16:   i = mk(OP_MOV, R_NB2, R_A0I, R_N6);
				5'd17:   i = mk(OP_MUL, R_NA1, R_N6, R_T0);
				5'd18:   i = mk(OP_SUB, R_NB1, R_T0, R_T0);
				5'd19:   i = mk(OP_DIV, R_T0, R_N3, R_N5);
				5'd20:   i = mk(OP_MUL, R_N0, R_N5, R_T0);
				5'd21:   i = mk(OP_MUL, R_T0, R_N3, R_T0);
				5'd22:   i = mk(OP_SUB, R_NB0, R_T0, R_T0);
				5'd23:   i = mk(OP_MUL, R_N1, R_N6, R_T1);
				5'd24:   i = mk(OP_SUB, R_T0, R_T1, R_T0);
				5'd25:   i = mk(OP_MUL, R_N2, R_N3, R_T1);
				5'd26:   i = mk(OP_DIV, R_T0, R_T1, R_N4);
				default: i = mk(OP_END, R_A0I, R_A0I, R_A0I);
			endcase
		end
		return i;
	endfunction

endpackage

`default_nettype wire

[rtl/biquad_coefficient_form_converter.sv]
// One item at a time: the next item is taken once the result is registered.
// Arithmetic runs on the shared serial unit: 33-step multiply, 56-step divide and
// 28-step square root, each operand pair fetched from a dual-read scratch RAM.
// Reset clears control state, sets the first-pass flag and the weight to 13107.
`default_nettype none

module biquad_coefficient_form_converter import bqc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [1:0]  kind,
	input  wire logic signed [31:0] a0_inv,
	input  wire logic signed [31:0] fb_a1,
	input  wire logic signed [31:0] fb_a2,
	input  wire logic signed [31:0] ff_b0,
	input  wire logic signed [31:0] ff_b1,
	input  wire logic signed [31:0] ff_b2,
	input  wire logic signed [31:0] clip_gain,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [31:0] coef_0,
	output logic signed      [31:0] coef_1,
	output logic signed      [31:0] coef_2,
	output logic signed      [31:0] coef_3,
	output logic signed      [31:0] coef_4,
	output logic signed      [31:0] coef_5,
	output logic signed      [31:0] coef_6,
	output logic signed      [31:0] coef_7,
	output logic                    saturated,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [15:0] smooth_weight
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_READ, S_START, S_WAIT, S_SREAD, S_SSTART, S_SWAIT, S_OUT
	} state_t;

	localparam int          LD_WORDS = 7;
	localparam logic [2:0]  LD_LAST  = 3'(LD_WORDS - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(COEF_COUNT - 1);

	state_t             state_q;
	logic        [PC_W-1:0]  pc_q;
	logic        [IDX_W-1:0] idx_q;
	logic        [2:0]  ld_cnt_q;
	logic               lat_q;
	logic               restart_q;
	logic               first_q;
	logic               item_sat_q;
	logic        [15:0] weight_q;
	logic               out_valid_q;
	logic               saturated_q;
	logic signed [31:0] coef_q [COEF_COUNT];
	logic signed [31:0] ld_q [LD_WORDS];
	logic signed [31:0] tgt_q [COEF_COUNT];

	logic               in_acc, out_free;
	instr_t             instr;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic signed [31:0] alu_res;
	logic               ram_we;
	logic [RAM_AW-1:0]  ram_waddr, ram_ra, ram_rb;
	logic [31:0]        ram_wdata, ram_da, ram_db;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign instr    = prog(lat_q, pc_q);

	// scratch RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = RAM_AW'(ld_cnt_q);
		ram_wdata = ld_q[0];
		ram_ra    = instr.ra;
		ram_rb    = instr.rb;
		if (state_q == S_SREAD || state_q == S_SSTART || state_q == S_SWAIT) begin
			ram_ra = R_N0 + RAM_AW'(idx_q);
		end
		if (state_q == S_LOAD) begin
			ram_we = 1'b1;
		end else if (state_q == S_WAIT && alu_rsp.done) begin
			ram_we    = 1'b1;
			ram_waddr = instr.rd;
			ram_wdata = alu_res;
		end
	end

	bqc_ram #(
		.WIDTH (32),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_ra),
		.raddr_b (ram_rb),
		.rdata_a (ram_da),
		.rdata_b (ram_db)
	);

	// arithmetic unit request
	always_comb begin
		alu_req.start = (state_q == S_START) || (state_q == S_SSTART);
		alu_req.op    = (state_q == S_SSTART) ? OP_SMOOTH : instr.op;
		alu_req.first = first_q;
	end

	bqc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (signed'(ram_da)),
		.opb    ((state_q == S_SSTART) ? tgt_q[0] : signed'(ram_db)),
		.weight (weight_q),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	// input word shift line and target ring
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			ld_q[0] <= a0_inv;
			ld_q[1] <= fb_a1;
			ld_q[2] <= fb_a2;
			ld_q[3] <= ff_b0;
			ld_q[4] <= ff_b1;
			ld_q[5] <= ff_b2;
			ld_q[6] <= clip_gain;
		end else if (state_q == S_LOAD) begin
			for (int j = 0; j < LD_WORDS - 1; j++) begin
				ld_q[j] <= ld_q[j + 1];
			end
		end
		if (state_q == S_SWAIT && alu_rsp.done) begin
			for (int j = 0; j < COEF_COUNT - 1; j++) begin
				tgt_q[j] <= tgt_q[j + 1];
			end
			tgt_q[COEF_COUNT - 1] <= alu_res;
		end
	end

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			idx_q       <= '0;
			ld_cnt_q    <= '0;
			lat_q       <= 1'b0;
			restart_q   <= 1'b0;
			first_q     <= 1'b1;
			item_sat_q  <= 1'b0;
			weight_q    <= WEIGHT_RESET;
			out_valid_q <= 1'b0;
			saturated_q <= 1'b0;
			for (int j = 0; j < COEF_COUNT; j++) begin
				coef_q[j] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				weight_q <= smooth_weight;
			end
			// output transfer frees the register unless a new result lands now
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						lat_q      <= kind[0];
						restart_q  <= kind[1];
						item_sat_q <= 1'b0;
						ld_cnt_q   <= '0;
						pc_q       <= '0;
						idx_q      <= '0;
						state_q    <= kind[1] ? S_OUT : S_LOAD;
					end
				end
				S_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 3'd1;
					if (ld_cnt_q == LD_LAST) begin
						state_q <= S_READ;
					end
				end
				S_READ:  state_q <= (instr.op == OP_END) ? S_SREAD : S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (alu_rsp.done) begin
						item_sat_q <= item_sat_q | alu_rsp.sat;
						pc_q       <= pc_q + 1'b1;
						state_q    <= S_READ;
					end
				end
				S_SREAD:  state_q <= S_SSTART;
				S_SSTART: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (alu_rsp.done) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == IDX_LAST) ? S_OUT : S_SREAD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						for (int j = 0; j < COEF_COUNT; j++) begin
							coef_q[j] <= restart_q ? 32'sd0 : tgt_q[j];
						end
						saturated_q <= restart_q ? 1'b0 : item_sat_q;
						out_valid_q <= 1'b1;
						first_q     <= restart_q;
						state_q     <= S_IDLE;
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	// weight only changes between items
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign saturated = saturated_q;
	assign coef_0    = coef_q[0];
	assign coef_1    = coef_q[1];
	assign coef_2    = coef_q[2];
	assign coef_3    = coef_q[3];
	assign coef_4    = coef_q[4];
	assign coef_5    = coef_q[5];
	assign coef_6    = coef_q[6];
	assign coef_7    = coef_q[7];

`ifndef ASSERT_OFF
	// the unit only finishes while the sequencer waits for it
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_WAIT || state_q == S_SWAIT))
		else $error("arithmetic unit finished with no operation pending");

	// an accepted item either loads or, on restart, goes straight to output
	a_accept_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_LOAD || state_q == S_OUT))
		else $error("accepted item took no valid path");

	// a restart transfer gives zeros and rearms the first pass
	a_restart_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && restart_q) |=>
			(coef_q[0] == 32'sd0 && !saturated_q && first_q && out_valid_q))
		else $error("restart result not cleared");
`endif

endmodule

`default_nettype wire

[rtl/bqc_ram.sv]
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module bqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

[rtl/bqc_alu.sv]
// Shared serial arithmetic unit: Q8.24 multiply, divide, square root and smoothing.
`default_nettype none

module bqc_alu import bqc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire alu_req_t           req,
	input  wire logic signed [31:0] opa,
	input  wire logic signed [31:0] opb,
	input  wire logic        [15:0] weight,
	output alu_rsp_t                rsp,
	output logic signed      [31:0] res
);

	typedef enum logic [2:0] {
		A_IDLE, A_MUL, A_MFIN, A_ROOT, A_RFIN, A_DIV, A_DFIN, A_DONE
	} astate_t;

	localparam logic [5:0] MUL_LAST  = 6'd32;
	localparam logic [5:0] ROOT_LAST = 6'd27;
	localparam logic [5:0] DIV_LAST  = 6'd55;
	localparam logic signed [67:0] MAX68 = 68'sd2147483647;
	localparam logic signed [67:0] MIN68 = -68'sd2147483648;

	astate_t            state_q;
	op_t                op_q;
	logic signed [31:0] b_q;
	logic        [5:0]  cnt_q;
	logic signed [33:0] ma_q;
	logic signed [34:0] mhi_q;
	logic        [32:0] mlo_q;
	logic        [55:0] rad_q;
	logic        [27:0] root_q;
	logic        [29:0] rem_q;
	logic        [55:0] dq_q;
	logic        [31:0] drem_q;
	logic        [31:0] dm_q;
	logic               dneg_q;
	logic signed [31:0] res_q;
	logic               sat_q;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > MAX68) return Q_MAX;
		if (v < MIN68) return Q_MIN;
		return v[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [67:0] v);
		return (v > MAX68) || (v < MIN68);
	endfunction

	// multiplier step: signed shift-add, sign bit of the multiplier subtracts
	logic signed [34:0] madd, msum;
	logic signed [67:0] prod, prod_r24, prod_r16;
	logic signed [43:0] q24;
	logic signed [32:0] inc16;
	logic signed [32:0] smooth_sum;
	logic signed [44:0] sq;
	logic        [44:0] nsq;
	always_comb begin
		madd = '0;
		if (mlo_q[0]) begin
			madd = (cnt_q == MUL_LAST) ? -{ma_q[33], ma_q} : {ma_q[33], ma_q};
		end
		msum       = mhi_q + madd;
		prod       = {mhi_q, mlo_q};
		prod_r24   = prod + 68'sd8388608;
		prod_r16   = prod + 68'sd32768;
		q24        = prod_r24[67:24];
		inc16      = prod_r16[48:16];
		smooth_sum = {b_q[31], b_q} + inc16;
		sq         = {q24[43], q24} - ({{13{b_q[31]}}, b_q} <<< 2);
		nsq        = 45'd0 - sq;
	end

	// square root step: two radicand bits a cycle
	logic [31:0] rem2, trial, rdiff;
	always_comb begin
		rem2  = {rem_q, rad_q[55:54]};
		trial = {2'b00, root_q, 2'b01};
		rdiff = rem2 - trial;
	end

	// divider step: one quotient bit a cycle
	logic [32:0] r2, ddiff;
	logic        dge;
	always_comb begin
		r2    = {drem_q, dq_q[55]};
		ddiff = r2 - {1'b0, dm_q};
		dge   = r2 >= {1'b0, dm_q};
	end

	// operations done without iteration, and operand magnitudes
	logic signed [32:0] add33, sub33, ar33, nega, negb;
	logic        [31:0] abs_a, abs_b;
	always_comb begin
		add33 = {opa[31], opa} + {opb[31], opb};
		sub33 = {opa[31], opa} - {opb[31], opb};
		ar33  = 33'sd1 - {opa[31], opa};
		nega  = -{opa[31], opa};
		negb  = -{opb[31], opb};
		abs_a = opa[31] ? nega[31:0] : opa;
		abs_b = opb[31] ? negb[31:0] : opb;
	end

	// sequencer of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			op_q    <= OP_END;
			b_q     <= '0;
			cnt_q   <= '0;
			ma_q    <= '0;
			mhi_q   <= '0;
			mlo_q   <= '0;
			rad_q   <= '0;
			root_q  <= '0;
			rem_q   <= '0;
			dq_q    <= '0;
			drem_q  <= '0;
			dm_q    <= '0;
			dneg_q  <= 1'b0;
			res_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						b_q   <= opb;
						cnt_q <= '0;
						sat_q <= 1'b0;
						mhi_q <= '0;
						state_q <= A_DONE;
						case (req.op)
							OP_MUL: begin
								ma_q    <= {opa[31], opa[31], opa};
								mlo_q   <= {opb[31], opb};
								state_q <= A_MUL;
							end
							OP_AI: begin
								ma_q    <= {opa[31], opa[31], opa};
								mlo_q   <= {opa[31], opa};
								state_q <= A_MUL;
							end
							OP_SMOOTH: begin
								if (req.first) begin
									res_q <= opa;
								end else begin
									ma_q    <= {18'd0, weight};
									mlo_q   <= sub33;
									state_q <= A_MUL;
								end
							end
							OP_DIV: begin
								if (opb == '0) begin
									res_q <= opa[31] ? Q_MIN : Q_MAX;
									sat_q <= 1'b1;
								end else begin
									dq_q    <= {abs_a, 24'd0};
									drem_q  <= '0;
									dm_q    <= abs_b;
									dneg_q  <= opa[31] ^ opb[31];
									state_q <= A_DIV;
								end
							end
							OP_SQRT: begin
								rad_q   <= {abs_a, 24'd0};
								root_q  <= '0;
								rem_q   <= '0;
								state_q <= A_ROOT;
							end
							OP_ADD: begin
								res_q <= sat32({{35{add33[32]}}, add33});
								sat_q <= ovf32({{35{add33[32]}}, add33});
							end
							OP_SUB: begin
								res_q <= sat32({{35{sub33[32]}}, sub33});
								sat_q <= ovf32({{35{sub33[32]}}, sub33});
							end
							OP_AR:   res_q <= ar33[32:1];
							OP_ONE:  res_q <= Q_ONE;
							OP_ZERO: res_q <= '0;
							default: res_q <= opa;
						endcase
					end
				end
				A_MUL: begin
					mhi_q <= {msum[34], msum[34:1]};
					mlo_q <= {msum[0], mlo_q[32:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) begin
						state_q <= A_MFIN;
					end
				end
				A_MFIN: begin
					cnt_q   <= '0;
					state_q <= A_DONE;
					case (op_q)
						OP_SMOOTH: res_q <= smooth_sum[31:0];
						OP_AI: begin
							// sq limited to at most zero, root of -sq scaled by 2^22
							rad_q   <= sq[44] ? {nsq[33:0], 22'd0} : 56'd0;
							root_q  <= '0;
							rem_q   <= '0;
							state_q <= A_ROOT;
						end
						default: begin
							res_q <= sat32({{24{q24[43]}}, q24});
							sat_q <= ovf32({{24{q24[43]}}, q24});
						end
					endcase
				end
				A_ROOT: begin
					rad_q <= {rad_q[53:0], 2'b00};
					if (rem2 >= trial) begin
						rem_q  <= rdiff[29:0];
						root_q <= {root_q[26:0], 1'b1};
					end else begin
						rem_q  <= rem2[29:0];
						root_q <= {root_q[26:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == ROOT_LAST) begin
						state_q <= A_RFIN;
					end
				end
				A_RFIN: begin
					// pole imaginary part floored at 16 epsilon
					if (op_q == OP_AI && root_q < 28'd16) begin
						res_q <= 32'sd16;
					end else begin
						res_q <= {4'd0, root_q};
					end
					state_q <= A_DONE;
				end
				A_DIV: begin
					drem_q <= dge ? ddiff[31:0] : r2[31:0];
					dq_q   <= {dq_q[54:0], dge};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= A_DFIN;
					end
				end
				A_DFIN: begin
					if (dneg_q) begin
						if (dq_q > 56'd2147483648) begin
							res_q <= Q_MIN;
							sat_q <= 1'b1;
						end else begin
							res_q <= 32'd0 - dq_q[31:0];
						end
					end else if (dq_q > 56'd2147483647) begin
						res_q <= Q_MAX;
						sat_q <= 1'b1;
					end else begin
						res_q <= dq_q[31:0];
					end
					state_q <= A_DONE;
				end
				A_DONE: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == A_DONE);
	assign rsp.sat  = sat_q;
	assign res      = res_q;

endmodule

`default_nettype wire

[test/tb_biquad_coefficient_form_converter.sv]
// Self-checking testbench for the biquad coefficient form converter.
`timescale 1ns / 100ps

module tb_biquad_coefficient_form_converter;
	import bqc_pkg::*;

	localparam logic [1:0] KIND_COUPLED = 2'd0;
	localparam logic [1:0] KIND_LATTICE = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_SPARE   = 2'd3;
	localparam longint QV_MAX = 64'sd2147483647;
	localparam longint QV_MIN = -64'sd2147483648;
	localparam longint QV_ONE = 64'sd16777216;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 322;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] a0i, a1, a2, b0, b1, b2, g;
	} coef_req_t;

	typedef struct packed {
		logic [7:0][31:0] c;
		logic             sat;
	} coef_set_t;

	typedef struct packed {
		coef_req_t req;
		logic      typed;
		coef_set_t want;
	} stim_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic [1:0] kind;
	logic signed [31:0] a0_inv, fb_a1, fb_a2, ff_b0, ff_b1, ff_b2, clip_gain;
	logic signed [31:0] coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7;
	logic saturated;
	logic [15:0] smooth_weight;

	// typed expectation travelling with the item on the input port
	logic      drv_typed;
	coef_set_t drv_want;

	// predictor state
	longint    tgt [8];
	logic      tgt_first;
	logic [15:0] weight_copy;
	logic      step_sat;

	coef_set_t coef_fifo [$];
	int        errors;
	int        hold_cycles;
	logic      quiet;
	int        stall_left;

	biquad_coefficient_form_converter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .a0_inv(a0_inv), .fb_a1(fb_a1), .fb_a2(fb_a2),
		.ff_b0(ff_b0), .ff_b1(ff_b1), .ff_b2(ff_b2), .clip_gain(clip_gain),
		.out_valid(out_valid), .out_stall(out_stall),
		.coef_0(coef_0), .coef_1(coef_1), .coef_2(coef_2), .coef_3(coef_3),
		.coef_4(coef_4), .coef_5(coef_5), .coef_6(coef_6), .coef_7(coef_7),
		.saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .smooth_weight(smooth_weight)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Q8.24 helpers
	function automatic longint clamp_q(input longint v);
		if (v > QV_MAX) begin
			step_sat = 1'b1;
			return QV_MAX;
		end
		if (v < QV_MIN) begin
			step_sat = 1'b1;
			return QV_MIN;
		end
		return v;
	endfunction

	function automatic longint mul_round(input longint a, input longint b);
		return (a * b + 64'sd8388608) >>> 24;
	endfunction

	function automatic longint mul_q(input longint a, input longint b);
		return clamp_q(mul_round(a, b));
	endfunction

	function automatic longint div_q(input longint n, input longint d);
		if (d == 0) begin
			step_sat = 1'b1;
			return (n < 0) ? QV_MIN : QV_MAX;
		end
		return clamp_q((n * QV_ONE) / d);
	endfunction

	function automatic longint root_floor(input longint unsigned x);
		longint unsigned r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt = bt >> 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint root_abs_q(input longint x);
		longint unsigned m;
		m = (x < 0) ? longint'(-x) : x;
		return root_floor(m << 24);
	endfunction

	// Converts one coefficient set and folds it into the smoothed targets, or clears them on restart
	function automatic coef_set_t convert_and_smooth(input coef_req_t r);
		coef_set_t res;
		longint a1, a2, b0, b1, b2, a0, ar, sq, ai, bb1, bb2, k1, q1, q2, v2, num, diff;
		longint nw [8];
		res = '0;
		step_sat = 1'b0;
		if (r.kind == KIND_RESTART || r.kind == KIND_SPARE) begin
			foreach (tgt[i]) tgt[i] = 0;
			tgt_first = 1'b1;
			return res;
		end
		a0 = r.a0i;
		a1 = mul_q(r.a1, a0);
		a2 = mul_q(r.a2, a0);
		b0 = mul_q(r.b0, a0);
		b1 = mul_q(r.b1, a0);
		b2 = mul_q(r.b2, a0);
		if (r.kind == KIND_COUPLED) begin
			ar = (1 - a1) >>> 1;
			sq = mul_round(a1, a1) - 4 * a2;
			if (sq > 0) sq = 0;
			ai = root_floor(longint'(-sq) << 22);
			if (ai < 16) ai = 16;
			bb1 = clamp_q(b1 - mul_q(a1, b0));
			bb2 = clamp_q(b2 - mul_q(a2, b0));
			nw[0] = ar;
			nw[1] = ai;
			nw[2] = QV_ONE;
			nw[3] = 0;
			nw[4] = bb1;
			nw[5] = div_q(clamp_q(mul_q(bb1, ar) + bb2), ai);
			nw[6] = b0;
		end else begin
			k1 = div_q(a1, clamp_q(QV_ONE + a2));
			q1 = root_abs_q(clamp_q(QV_ONE - mul_q(k1, k1)));
			q2 = root_abs_q(clamp_q(QV_ONE - mul_q(a2, a2)));
			v2 = div_q(clamp_q(b1 - mul_q(a1, b2)), q2);
			num = clamp_q(clamp_q(b0 - mul_q(mul_q(k1, v2), q2)) - mul_q(a2, b2));
			nw[0] = k1;
			nw[1] = a2;
			nw[2] = q1;
			nw[3] = q2;
			nw[4] = div_q(num, mul_q(q1, q2));
			nw[5] = v2;
			nw[6] = b2;
		end
		nw[7] = r.g;
		for (int i = 0; i < 8; i++) begin
			if (tgt_first) begin
				tgt[i] = nw[i];
			end else begin
				diff = nw[i] - tgt[i];
				tgt[i] = tgt[i] + ((diff * longint'(weight_copy) + 64'sd32768) >>> 16);
			end
			res.c[i] = tgt[i][31:0];
		end
		tgt_first = 1'b0;
		res.sat = step_sat;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// Monitor: predicts on input transfer, checks on output transfer
	always @(posedge clk) begin
		coef_set_t exp_set, got_set;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) weight_copy <= smooth_weight;
			if (in_valid && !in_stall) begin
				exp_set = convert_and_smooth({kind, a0_inv, fb_a1, fb_a2, ff_b0, ff_b1,
					ff_b2, clip_gain});
				coef_fifo.push_back(drv_typed ? drv_want : exp_set);
			end
			if (out_valid && !out_stall) begin
				got_set.c = {coef_7, coef_6, coef_5, coef_4, coef_3, coef_2, coef_1, coef_0};
				got_set.sat = saturated;
				if (coef_fifo.size() == 0) begin
					report_mismatch("unexpected result", got_set.c[0], 32'h0);
				end else begin
					exp_set = coef_fifo.pop_front();
					for (int i = 0; i < 8; i++)
						if (got_set.c[i] !== exp_set.c[i])
							report_mismatch($sformatf("coef_%0d", i), got_set.c[i], exp_set.c[i]);
					if (got_set.sat !== exp_set.sat)
						report_mismatch("saturated", got_set.sat, exp_set.sat);
				end
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(input coef_req_t r, input logic typed, input coef_set_t want);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		{kind, a0_inv, fb_a1, fb_a2, ff_b0, ff_b1, ff_b2, clip_gain} <= r;
		drv_typed <= typed;
		drv_want  <= want;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// let the monitor queue the last transfer before waiting for the queue to empty
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (coef_fifo.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_weight(input logic [15:0] w);
		cfg_valid     <= 1'b1;
		smooth_weight <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] near(input int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly plausible filters, some raw noise
	function automatic coef_req_t random_req();
		coef_req_t r;
		int sel;
		sel = $urandom_range(0, 19);
		r.kind = (sel == 0) ? KIND_RESTART : (sel == 1) ? KIND_SPARE
			: ($urandom_range(0, 1) ? KIND_LATTICE : KIND_COUPLED);
		if ($urandom_range(0, 3) == 0) begin
			r.a0i = $urandom; r.a1 = $urandom; r.a2 = $urandom;
			r.b0 = $urandom; r.b1 = $urandom; r.b2 = $urandom; r.g = $urandom;
		end else begin
			r.a0i = 32'sh0100_0000 + near(32'h0080_0000);
			r.a1  = near(32'h0200_0000);
			r.a2  = near(32'h0100_0000);
			r.b0  = near(32'h0200_0000);
			r.b1  = near(32'h0400_0000);
			r.b2  = near(32'h0200_0000);
			r.g   = $urandom;
		end
		return r;
	endfunction

	stim_row_t directed [] ;
	coef_set_t zero_set, flat_set;
	logic [15:0] phase_weight [PHASES];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; cfg_valid = 1'b0; out_stall = 1'b0;
		kind = KIND_COUPLED; a0_inv = '0; fb_a1 = '0; fb_a2 = '0;
		ff_b0 = '0; ff_b1 = '0; ff_b2 = '0; clip_gain = '0;
		smooth_weight = WEIGHT_RESET;
		drv_typed = 1'b0; drv_want = '0;
		errors = 0; hold_cycles = 0; stall_left = 0; quiet = 1'b0;
		foreach (tgt[i]) tgt[i] = 0;
		tgt_first = 1'b1;
		weight_copy = WEIGHT_RESET;

		zero_set = '0;
		flat_set = '0;
		flat_set.c[1] = 32'd16;
		flat_set.c[2] = Q_ONE;

		// restart, flat filter on first pass, extremes, divide by zero, spare kind
		directed = '{
			'{'{KIND_RESTART, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1, zero_set},
			'{'{KIND_COUPLED, Q_ONE, 0, 0, 0, 0, 0, 0}, 1'b1, flat_set},
			'{'{KIND_LATTICE, Q_ONE, 32'sh0080_0000, 32'sh0040_0000, Q_ONE,
				32'sh0020_0000, 32'sh0010_0000, Q_ONE}, 1'b0, zero_set},
			'{'{KIND_LATTICE, Q_ONE, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0}, 1'b0, zero_set},
			'{'{KIND_LATTICE, Q_ONE, 0, Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE}, 1'b0, zero_set},
			'{'{KIND_COUPLED, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b0, zero_set},
			'{'{KIND_COUPLED, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, zero_set},
			'{'{KIND_SPARE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1, zero_set},
			'{'{KIND_LATTICE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, zero_set},
			'{'{KIND_LATTICE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b0, zero_set},
			'{'{KIND_COUPLED, Q_ONE, -32'sh0180_0000, 32'sh00c0_0000, 32'sh0040_0000,
				32'sh0080_0000, 32'sh0040_0000, Q_ONE}, 1'b0, zero_set},
			'{'{KIND_COUPLED, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, -1}, 1'b0, zero_set},
			'{'{KIND_LATTICE, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1}, 1'b0, zero_set},
			'{'{KIND_COUPLED, -Q_ONE, Q_ONE, -Q_ONE, -1, 1, -1, Q_MIN}, 1'b0, zero_set},
			'{'{KIND_RESTART, 0, 0, 0, 0, 0, 0, 0}, 1'b1, zero_set},
			'{'{KIND_LATTICE, Q_ONE, -Q_ONE, 0, Q_MAX, Q_MIN, Q_MAX, Q_MAX}, 1'b0, zero_set}
		};

		phase_weight[0] = 16'd0;
		phase_weight[1] = 16'hffff;
		phase_weight[2] = WEIGHT_RESET;
		phase_weight[3] = 16'($urandom);
		phase_weight[4] = 16'd1;
		phase_weight[5] = 16'($urandom);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset weight
		foreach (directed[i]) send_item(directed[i].req, directed[i].typed, directed[i].want);
		drain_results();

		// random phases, each at its own smoothing weight
		for (int p = 0; p < PHASES; p++) begin
			write_weight(phase_weight[p]);
			quiet = (p == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off so the block backs up onto its input
				if (p == 1 && n == 20) hold_cycles <= 3000;
				send_item(random_req(), 1'b0, zero_set);
			end
			drain_results();
		end

		repeat (50) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	// run limit
	initial begin
		#150_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/bqc_pkg.sv
rtl/bqc_ram.sv
rtl/bqc_alu.sv
rtl/biquad_coefficient_form_converter.sv
test/tb_biquad_coefficient_form_converter.sv
